// ===== src/dwg_pkg.sv =====
// ----------------------------------------------------------------------------
// dwg_pkg
// Shared types, constants and constant tables of the DAC waveform generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dwg_pkg;

  // Default sizing of the generator
  localparam int DWG_TICK_RATE   = 1000;
  localparam int DWG_PHASE_BITS  = 32;

  // Field widths
  localparam int FREQ_BITS       = 8;
  localparam int TYPE_BITS       = 2;
  localparam int SAMPLE_BITS     = 8;
  localparam int CFG_DATA_BITS   = 8;
  localparam int CFG_INDEX_BITS  = 2;

  // Frequency after reset, in hertz
  localparam logic [FREQ_BITS-1:0] FREQ_RESET = 8'd5;
  localparam int FREQ_CODES = 2 ** FREQ_BITS;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_FREQUENCY = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_TYPE      = 2'd1;

  // Wave shapes
  typedef enum logic [TYPE_BITS-1:0] {
    WAVE_PULSE    = 2'd0,
    WAVE_SINE     = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAWTOOTH = 2'd3
  } wave_type_t;

  // Control from the handshake logic to the phase unit
  typedef struct packed {
    logic advance;      // step the phase by one tick
    logic freq_write;   // load a new increment
    logic pulse_clear;  // wave type changed
  } dwg_ctrl_t;

  // Sine resolution: top bits of the phase that address the wave
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_HALF       = 2 ** (SINE_TABLE_BITS - 1);
  localparam int SINE_QUARTER    = 2 ** (SINE_TABLE_BITS - 2);

  // Codes at the quarter-wave peak, and the two pulse levels
  localparam logic [SAMPLE_BITS-1:0] SINE_PEAK_HIGH = 8'd255;
  localparam logic [SAMPLE_BITS-1:0] SINE_PEAK_LOW  = 8'd1;
  localparam logic [SAMPLE_BITS-1:0] PULSE_HIGH     = 8'd255;
  localparam logic [SAMPLE_BITS-1:0] PULSE_LOW      = 8'd0;

  // Q30 fixed point
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] MID_Q30     = 64'd128 << 30;

  // Build the quarter-wave sample codes for points 0 .. quarter-1.
  // lower selects the falling half (128 - 127*sin) instead of 128 + 127*sin.
  function automatic logic [SINE_QUARTER*SAMPLE_BITS-1:0] build_sine_table(
    input logic lower
  );
    logic [SINE_QUARTER*SAMPLE_BITS-1:0] tab;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] mag;
    logic [63:0] v;
    logic signed [63:0] sum;
    int q;
    int k;
    tab = '0;
    for (q = 0; q < SINE_QUARTER; q++) begin
      if (q == 0) begin
        mag = '0;
      end else begin
        // Taylor series of sin up to the x^17 term
        x    = (64'(q) * HALF_PI_Q30) / 64'(SINE_QUARTER);
        term = x;
        sum  = signed'(x);
        for (k = 1; k <= 8; k++) begin
          term = (((term * x) >> 30) * x) >> 30;
          term = term / 64'((2 * k) * (2 * k + 1));
          if ((k & 1) != 0) begin
            sum = sum - signed'(term);
          end else begin
            sum = sum + signed'(term);
          end
        end
        if (sum < 0) begin
          sum = '0;
        end
        mag = (unsigned'(sum) > Q30_ONE) ? Q30_ONE : unsigned'(sum);
      end
      v = lower ? (MID_Q30 - 64'd127 * mag) : (MID_Q30 + 64'd127 * mag);
      tab[q*SAMPLE_BITS +: SAMPLE_BITS] = v[37:30];
    end
    return tab;
  endfunction

  localparam logic [SINE_QUARTER*SAMPLE_BITS-1:0] SINE_UPPER_TABLE = build_sine_table(1'b0);
  localparam logic [SINE_QUARTER*SAMPLE_BITS-1:0] SINE_LOWER_TABLE = build_sine_table(1'b1);

endpackage

`default_nettype wire

// ===== src/dwg_phase.sv =====
// ----------------------------------------------------------------------------
// dwg_phase
// Phase accumulator, per-tick increment register and pulse level.
// ----------------------------------------------------------------------------
`default_nettype none

module dwg_phase import dwg_pkg::*; #(
  parameter int TICK_RATE  = DWG_TICK_RATE,
  parameter int PHASE_BITS = DWG_PHASE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dwg_ctrl_t             ctrl,
  input  logic [FREQ_BITS-1:0]  frequency,
  output logic [PHASE_BITS-1:0] phase,
  output logic                  pulse_level
);

  localparam int INC_BITS = PHASE_BITS + FREQ_BITS;

  // Increment per tick for every frequency code: floor(f * 2^PHASE_BITS / TICK_RATE)
  function automatic logic [FREQ_CODES*INC_BITS-1:0] build_inc_table();
    logic [FREQ_CODES*INC_BITS-1:0] tab;
    logic [63:0] v;
    int f;
    tab = '0;
    for (f = 0; f < FREQ_CODES; f++) begin
      v = (64'(f) << PHASE_BITS) / 64'(TICK_RATE);
      tab[f*INC_BITS +: INC_BITS] = v[INC_BITS-1:0];
    end
    return tab;
  endfunction

  localparam logic [FREQ_CODES*INC_BITS-1:0] INC_TABLE = build_inc_table();
  localparam logic [INC_BITS-1:0] INC_RESET =
    INC_TABLE[int'(FREQ_RESET)*INC_BITS +: INC_BITS];

  logic [INC_BITS-1:0] increment;
  logic [INC_BITS:0]   sum;

  // Wrap count parity is the bit just above the phase
  assign sum = {{(FREQ_BITS + 1){1'b0}}, phase} + {1'b0, increment};

  // Load the increment on a frequency write
  always_ff @(posedge clk) begin
    if (rst) begin
      increment <= INC_RESET;
    end else if (ctrl.freq_write) begin
      increment <= INC_TABLE[frequency*INC_BITS +: INC_BITS];
    end
  end

  // Advance the phase, toggle the level on an odd number of wraps
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      pulse_level <= 1'b0;
    end else begin
      if (ctrl.advance) begin
        phase <= sum[PHASE_BITS-1:0];
      end
      if (ctrl.pulse_clear) begin
        pulse_level <= 1'b0;
      end else if (ctrl.advance && sum[PHASE_BITS]) begin
        pulse_level <= ~pulse_level;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/dwg_shape.sv =====
// ----------------------------------------------------------------------------
// dwg_shape
// Maps the phase to an 8-bit DAC code for the selected wave shape.
// ----------------------------------------------------------------------------
`default_nettype none

module dwg_shape import dwg_pkg::*; #(
  parameter int PHASE_BITS = DWG_PHASE_BITS
) (
  input  logic [PHASE_BITS-1:0]  phase,
  input  logic                   pulse_level,
  input  wave_type_t             wave_type,
  output logic [SAMPLE_BITS-1:0] sample
);

  logic [SINE_TABLE_BITS-1:0] sine_index;
  logic [SINE_TABLE_BITS-2:0] half_pos;
  logic [SINE_TABLE_BITS-2:0] quarter_pos;
  logic [SAMPLE_BITS-1:0]     sine_code;

  logic [PHASE_BITS:0]             phase_ext;
  logic [PHASE_BITS:0]             fold;
  logic [PHASE_BITS:0]             ramp;
  logic [PHASE_BITS+SAMPLE_BITS:0] scaled;
  logic [SAMPLE_BITS-1:0]          ramp_code;

  // Sine: mirror the quarter wave over the period
  assign sine_index = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign half_pos   = sine_index[SINE_TABLE_BITS-2:0];

  always_comb begin
    if (half_pos > (SINE_TABLE_BITS-1)'(SINE_QUARTER)) begin
      quarter_pos = (SINE_TABLE_BITS-1)'(SINE_HALF) - half_pos;
    end else begin
      quarter_pos = half_pos;
    end
    if (quarter_pos == (SINE_TABLE_BITS-1)'(SINE_QUARTER)) begin
      sine_code = sine_index[SINE_TABLE_BITS-1] ? SINE_PEAK_LOW : SINE_PEAK_HIGH;
    end else if (sine_index[SINE_TABLE_BITS-1]) begin
      sine_code = SINE_LOWER_TABLE[quarter_pos[SINE_TABLE_BITS-3:0]*SAMPLE_BITS +: SAMPLE_BITS];
    end else begin
      sine_code = SINE_UPPER_TABLE[quarter_pos[SINE_TABLE_BITS-3:0]*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  // Ramps: 255 * r / 2^PHASE_BITS, r = phase for saw, twice the folded phase
  // for triangle
  assign phase_ext = {1'b0, phase};

  always_comb begin
    if (phase[PHASE_BITS-1]) begin
      fold = {1'b1, {PHASE_BITS{1'b0}}} - phase_ext;
    end else begin
      fold = phase_ext;
    end
    if (wave_type == WAVE_TRIANGLE) begin
      ramp = {fold[PHASE_BITS-1:0], 1'b0};
    end else begin
      ramp = phase_ext;
    end
    scaled    = {ramp, {SAMPLE_BITS{1'b0}}} - {{SAMPLE_BITS{1'b0}}, ramp};
    ramp_code = scaled[PHASE_BITS +: SAMPLE_BITS];
  end

  // Select the shape
  always_comb begin
    unique case (wave_type)
      WAVE_PULSE:    sample = pulse_level ? PULSE_HIGH : PULSE_LOW;
      WAVE_SINE:     sample = sine_code;
      WAVE_TRIANGLE: sample = ramp_code;
      WAVE_SAWTOOTH: sample = ramp_code;
      default:       sample = PULSE_LOW;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/dac_waveform_generator.sv =====
// ----------------------------------------------------------------------------
// dac_waveform_generator
// Direct digital synthesis source of 8-bit DAC codes, one per timer tick.
// ----------------------------------------------------------------------------
// Each item on the input channel is one timer tick; the block answers every
// item with one DAC code taken from the phase as it stood before that tick,
// then (when advance is set) steps the phase by frequency / TICK_RATE of a
// period. It takes one item per clock cycle while the output is not stalled;
// the item is captured in an input register, the phase add feeds the phase
// register, and the shape logic and quarter-wave sine table sit in front
// of the result register. The phase increment is looked up from a constant
// table when the frequency register is written. Write the configuration only
// while no item is in flight; a change of wave type clears the pulse level.
// ----------------------------------------------------------------------------
`default_nettype none

module dac_waveform_generator import dwg_pkg::*; #(
  parameter int TICK_RATE  = DWG_TICK_RATE,
  parameter int PHASE_BITS = DWG_PHASE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration port
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // Tick input
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      advance,
  // Sample output
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SAMPLE_BITS-1:0]    sample
);

  logic                   item_valid;
  logic                   item_advance;
  logic                   in_take;
  logic                   item_move;
  wave_type_t             wave_type;
  logic                   type_write;
  dwg_ctrl_t              ctrl;
  logic [PHASE_BITS-1:0]  phase;
  logic                   pulse_level;
  logic [SAMPLE_BITS-1:0] shape_sample;

  // Handshake: the input register drains whenever the result register frees
  assign item_move = item_valid && !(out_valid && out_stall);
  assign in_stall  = item_valid && out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (item_move) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_advance <= advance;
    end
  end

  // Wave type register
  assign type_write = cfg_write_en && (cfg_index == REG_WAVE_TYPE);

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_type <= WAVE_PULSE;
    end else if (type_write) begin
      wave_type <= wave_type_t'(cfg_data[TYPE_BITS-1:0]);
    end
  end

  // Control to the phase unit
  always_comb begin
    ctrl.advance     = item_move && item_advance;
    ctrl.freq_write  = cfg_write_en && (cfg_index == REG_WAVE_FREQUENCY);
    ctrl.pulse_clear = type_write && (cfg_data[TYPE_BITS-1:0] != wave_type);
  end

  dwg_phase #(
    .TICK_RATE  (TICK_RATE),
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .frequency   (cfg_data[FREQ_BITS-1:0]),
    .phase       (phase),
    .pulse_level (pulse_level)
  );

  dwg_shape #(
    .PHASE_BITS (PHASE_BITS)
  ) u_shape (
    .phase       (phase),
    .pulse_level (pulse_level),
    .wave_type   (wave_type),
    .sample      (shape_sample)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_move) begin
      sample <= shape_sample;
    end
  end

endmodule

`default_nettype wire

// ===== src/dwg_checker.sv =====
// ----------------------------------------------------------------------------
// dwg_checker
// Port-level checks of the DAC waveform generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dwg_checker import dwg_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] sample
);

  // A stalled result keeps its code
  a_hold_sample: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sample)))
    else $error("sample changed while stalled");

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  // A rising result follows an item taken through the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching item");

  // With the input register full behind a stalled result, the input stalls
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(in_valid && !in_stall) && out_valid && out_stall) |-> in_stall)
    else $error("item taken with both stages full");

endmodule

bind dac_waveform_generator dwg_checker u_checker (.*);

`default_nettype wire
